// ===== rtl/vt4_pkg.sv =====
package vt4_pkg;

   // Fraction bits of the Q format; results are shifted right by this much
   localparam int FRAC_BITS = 16;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int DATA_W = 32;
   localparam int IDX_W = 4;
   localparam int DIM = 4;
   localparam int ELEM_CNT = DIM * DIM;
   localparam int PROD_W = 2 * DATA_W;
   // four products of magnitude up to 2^62 sum into 66 signed bits
   localparam int SUM_W = PROD_W + 2;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_XFORM = 1'b1
   } op_type;

   typedef logic signed [DATA_W-1:0] word_type;

   // Classified item as it sits in the queue
   typedef struct packed {
      op_type                       op;
      logic [IDX_W-1:0]             elem_index;
      logic [DATA_W-1:0]            elem_value;
      logic [DIM-1:0][DATA_W-1:0]   vec;
   } item_type;

endpackage

// ===== rtl/vt4_if.sv =====
// Request channel: one load or transform item
interface vt4_req_if import vt4_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    command;
   logic [IDX_W-1:0]        elem_index;
   logic signed [DATA_W-1:0] elem_value;
   logic signed [DATA_W-1:0] vec_x;
   logic signed [DATA_W-1:0] vec_y;
   logic signed [DATA_W-1:0] vec_z;
   logic signed [DATA_W-1:0] vec_w;

   modport source (
      output valid, command, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
      input  ready
   );
   modport sink (
      input  valid, command, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
      output ready
   );
endinterface

// Response channel: one transformed vector
interface vt4_rsp_if import vt4_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [DATA_W-1:0] out_x;
   logic signed [DATA_W-1:0] out_y;
   logic signed [DATA_W-1:0] out_z;
   logic signed [DATA_W-1:0] out_w;
   logic                    saturated;

   modport source (
      output valid, out_x, out_y, out_z, out_w, saturated,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_z, out_w, saturated,
      output ready
   );
endinterface

// ===== rtl/vt4_front.sv =====
module vt4_front import vt4_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   vt4_req_if.sink  req_ch,
   output item_type head_item,
   output logic     head_valid,
   input  logic     head_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type             queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   item_type             class_item;
   logic                 push;
   logic                 pop;

   // Classify: loads keep the element, transforms keep the vector
   always_comb begin
      class_item = '0;
      if (req_ch.command) begin
         class_item.op  = OP_XFORM;
         class_item.vec = {req_ch.vec_w, req_ch.vec_z, req_ch.vec_y, req_ch.vec_x};
      end else begin
         class_item.op         = OP_LOAD;
         class_item.elem_index = req_ch.elem_index;
         class_item.elem_value = req_ch.elem_value;
      end
   end

   assign req_ch.ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign head_valid   = (count_ff != '0);
   assign pop          = head_pop && head_valid;
   assign head_item    = queue_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= class_item;
      end
   end

endmodule

// ===== rtl/vt4_back.sv =====
module vt4_back import vt4_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  item_type   head_item,
   input  logic       head_valid,
   output logic       head_pop,
   vt4_rsp_if.source  rsp_ch
);

   word_type                 matrix_ff [ELEM_CNT];
   word_type                 vec_s [DIM];
   logic signed [PROD_W-1:0] prod_ff [ELEM_CNT];
   logic signed [PROD_W-1:0] prod_in [ELEM_CNT];
   logic                     prod_valid_ff;
   logic signed [SUM_W-1:0]  sum_ff [DIM];
   logic signed [SUM_W-1:0]  sum_in [DIM];
   logic                     sum_valid_ff;
   logic signed [SUM_W-1:0]  shifted [DIM];
   logic [SUM_W-DATA_W:0]    upper [DIM];
   word_type                 out_ff [DIM];
   word_type                 out_in [DIM];
   logic [DIM-1:0]           clip;
   logic                     sat_ff;
   logic                     out_valid_ff;
   logic                     advance;
   logic                     take_load;
   logic                     take_xform;

   // Whole pipeline moves unless the output holds an untaken item
   assign advance    = !out_valid_ff || rsp_ch.ready;
   assign head_pop   = advance;
   assign take_load  = advance && head_valid && (head_item.op == OP_LOAD);
   assign take_xform = head_valid && (head_item.op == OP_XFORM);

   // Matrix store, written in order with transforms
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ELEM_CNT; i++) begin
            matrix_ff[i] <= '0;
         end
      end else if (take_load) begin
         matrix_ff[head_item.elem_index] <= head_item.elem_value;
      end
   end

   // Stage 1: sixteen element products
   always_comb begin
      for (int c = 0; c < DIM; c++) begin
         vec_s[c] = head_item.vec[c];
      end
      for (int i = 0; i < ELEM_CNT; i++) begin
         prod_in[i] = matrix_ff[i] * vec_s[i % DIM];
      end
   end

   // Stage 2: row sums
   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         sum_in[r] = '0;
         for (int c = 0; c < DIM; c++) begin
            sum_in[r] = sum_in[r] + SUM_W'(prod_ff[r * DIM + c]);
         end
      end
   end

   // Stage 3: drop fraction bits and clip to 32 bits
   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         shifted[r] = sum_ff[r] >>> FRAC_BITS;
         upper[r]   = shifted[r][SUM_W-1:DATA_W-1];
         clip[r]    = (upper[r] != '0) && (upper[r] != '1);
         if (!clip[r]) begin
            out_in[r] = shifted[r][DATA_W-1:0];
         end else if (shifted[r][SUM_W-1]) begin
            out_in[r] = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            out_in[r] = {1'b0, {(DATA_W-1){1'b1}}};
         end
      end
   end

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= take_xform;
         sum_valid_ff  <= prod_valid_ff;
         out_valid_ff  <= sum_valid_ff;
      end
   end

   // Pipeline data
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         out_ff  <= out_in;
         sat_ff  <= |clip;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.out_x     = out_ff[0];
   assign rsp_ch.out_y     = out_ff[1];
   assign rsp_ch.out_z     = out_ff[2];
   assign rsp_ch.out_w     = out_ff[3];
   assign rsp_ch.saturated = sat_ff;

endmodule

// ===== rtl/vertex_transform_4x4_top.sv =====
// A transform item passes from the queue through the product, sum and output
// registers to rsp_ch.
// Throughput: one item per cycle, set by the three-stage multiply/sum/clip pipe,
// while no response waits untaken; load items take a slot but give no response.
// Reset (synchronous, active high) empties the queue and the pipe and clears
// all sixteen matrix elements to zero.
module vertex_transform_4x4_top import vt4_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   vt4_req_if.sink    req_ch,
   vt4_rsp_if.source  rsp_ch
);

   item_type head_item;
   logic     head_valid;
   logic     head_pop;

   // Accept and classify items into the queue
   vt4_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   // Matrix store and transform pipeline
   vt4_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ===== rtl/vt4_checker.sv =====
module vt4_checker import vt4_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_command,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_out_x,
   input logic [DATA_W-1:0] rsp_out_y,
   input logic [DATA_W-1:0] rsp_out_z,
   input logic [DATA_W-1:0] rsp_out_w,
   input logic              rsp_saturated
);

   localparam logic [DATA_W-1:0] MAX_W = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MIN_W = {1'b1, {(DATA_W-1){1'b0}}};

   logic [7:0] pending_ff, pending_in;
   logic       xform_in;
   logic       rsp_out;

   // Transforms accepted but not yet answered
   assign xform_in = req_valid && req_ready && req_command;
   assign rsp_out  = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (xform_in && !rsp_out) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_out && !xform_in) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // No response without a transform item ahead of it
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response with no outstanding transform item");

   // Reset empties the output
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Saturation flag implies a clipped component
   a_sat_clipped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_out_x == MAX_W || rsp_out_x == MIN_W ||
         rsp_out_y == MAX_W || rsp_out_y == MIN_W ||
         rsp_out_z == MAX_W || rsp_out_z == MIN_W ||
         rsp_out_w == MAX_W || rsp_out_w == MIN_W)
      else $error("saturated set but no component at a limit");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) &&
         $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_out_w) &&
         $stable(rsp_saturated))
      else $error("stalled response changed");

endmodule

bind vertex_transform_4x4_top vt4_checker u_vt4_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_command   (req_ch.command),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_out_x     (rsp_ch.out_x),
   .rsp_out_y     (rsp_ch.out_y),
   .rsp_out_z     (rsp_ch.out_z),
   .rsp_out_w     (rsp_ch.out_w),
   .rsp_saturated (rsp_ch.saturated)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import vt4_pkg::*;

   // cycles with no item accepted on either channel before the run is called hung
   localparam int QUIET_LIMIT = 5000;
   // length of the one long receiver hold-off
   localparam int HOLD_LEN = 300;
   localparam int ITEMS_PER_PHASE = 158;

   typedef struct {
      op_type            op;
      logic [IDX_W-1:0]  elem_index;
      word_type          elem_value;
      word_type          vec_x;
      word_type          vec_y;
      word_type          vec_z;
      word_type          vec_w;
   } vertex_req_type;

   typedef struct {
      word_type out_x;
      word_type out_y;
      word_type out_z;
      word_type out_w;
      logic     saturated;
   } vertex_rsp_type;

   // Keeps a private copy of the matrix and the transformed vertices still owed
   class vertex_scoreboard;
      localparam word_type W_MAX = 32'sh7FFF_FFFF;
      localparam word_type W_MIN = 32'sh8000_0000;

      word_type       matrix[ELEM_CNT];
      vertex_rsp_type expected_vertices[$];
      int             mismatches;

      function new();
         foreach (matrix[i]) matrix[i] = '0;
         mismatches = 0;
      endfunction

      // Q16.16 matrix times vector: exact 66-bit sums, arithmetic shift, clip
      function vertex_rsp_type transform_vertex(vertex_req_type it);
         word_type                  vec[DIM];
         word_type                  rows[DIM];
         logic signed [PROD_W-1:0]  prod;
         logic signed [SUM_W-1:0]   acc;
         logic signed [SUM_W-1:0]   scaled;
         vertex_rsp_type            res;
         vec = '{it.vec_x, it.vec_y, it.vec_z, it.vec_w};
         res.saturated = 1'b0;
         for (int r = 0; r < DIM; r++) begin
            acc = '0;
            for (int k = 0; k < DIM; k++) begin
               prod = matrix[r*DIM + k] * vec[k];
               acc = acc + prod;
            end
            scaled = acc >>> FRAC_BITS;
            if (scaled > W_MAX) begin
               rows[r] = W_MAX;
               res.saturated = 1'b1;
            end else if (scaled < W_MIN) begin
               rows[r] = W_MIN;
               res.saturated = 1'b1;
            end else begin
               rows[r] = scaled[DATA_W-1:0];
            end
         end
         res.out_x = rows[0];
         res.out_y = rows[1];
         res.out_z = rows[2];
         res.out_w = rows[3];
         return res;
      endfunction

      // A load updates the matrix; a transform queues its expected vertex
      function void note_item(vertex_req_type it);
         if (it.op == OP_LOAD) begin
            matrix[it.elem_index] = it.elem_value;
         end else begin
            expected_vertices.push_back(transform_vertex(it));
         end
      endfunction

      function void check_result(vertex_rsp_type got);
         vertex_rsp_type want;
         if (expected_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: vertex with none expected: %h %h %h %h sat %b", $realtime,
                        got.out_x, got.out_y, got.out_z, got.out_w, got.saturated);
            return;
         end
         want = expected_vertices.pop_front();
         if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
             got.out_z !== want.out_z || got.out_w !== want.out_w ||
             got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: vertex expected %h %h %h %h sat %b", $realtime,
                        want.out_x, want.out_y, want.out_z, want.out_w, want.saturated);
               $display("%0t:        got      %h %h %h %h sat %b", $realtime,
                        got.out_x, got.out_y, got.out_z, got.out_w, got.saturated);
            end
         end
      endfunction

      function int pending();
         return expected_vertices.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   vt4_req_if req_ch ();
   vt4_rsp_if rsp_ch ();

   vertex_transform_4x4_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   vertex_scoreboard sb = new();

   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   logic        hold_req;
   int          quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls per phase, plus one long hold-off on request
   initial begin : receiver
      int  hold_left;
      bit  hold_done;
      hold_left = HOLD_LEN;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
            if (hold_left == 0) hold_done = 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Accepted items feed the predictor before results are checked
   always @(posedge clock) begin
      vertex_req_type it;
      vertex_rsp_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            it.op = op_type'(req_ch.command);
            it.elem_index = req_ch.elem_index;
            it.elem_value = req_ch.elem_value;
            it.vec_x = req_ch.vec_x;
            it.vec_y = req_ch.vec_y;
            it.vec_z = req_ch.vec_z;
            it.vec_w = req_ch.vec_w;
            sb.note_item(it);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.out_x = rsp_ch.out_x;
            got.out_y = rsp_ch.out_y;
            got.out_z = rsp_ch.out_z;
            got.out_w = rsp_ch.out_w;
            got.saturated = rsp_ch.saturated;
            sb.check_result(got);
         end
      end
   end

   // Watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Mix of extremes, small and medium Q16.16 values, and raw random words
   function automatic word_type rand_word();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         case ($urandom_range(4))
            0: return 32'sh0000_0000;
            1: return 32'sh0000_0001;
            2: return 32'shFFFF_FFFF;
            3: return 32'sh7FFF_FFFF;
            default: return 32'sh8000_0000;
         endcase
      end else if (pick < 50) begin
         return int'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      end else if (pick < 80) begin
         return int'($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
      end
      return $urandom;
   endfunction

   // Offer one item, with a random gap first, and wait for it to be taken
   task automatic send_item(input op_type op, input logic [IDX_W-1:0] idx,
                            input word_type value, input word_type x, input word_type y,
                            input word_type z, input word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= op;
      req_ch.elem_index <= idx;
      req_ch.elem_value <= value;
      req_ch.vec_x <= x;
      req_ch.vec_y <= y;
      req_ch.vec_z <= z;
      req_ch.vec_w <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic load_elem(input int idx, input word_type value);
      send_item(OP_LOAD, idx[IDX_W-1:0], value, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic transform(input word_type x, input word_type y, input word_type z,
                            input word_type w);
      send_item(OP_XFORM, IDX_W'($urandom_range(ELEM_CNT-1)), $urandom, x, y, z, w);
   endtask

   task automatic send_random_item();
      if ($urandom_range(99) < 30)
         load_elem($urandom_range(ELEM_CNT-1), rand_word());
      else
         transform(rand_word(), rand_word(), rand_word(), rand_word());
   endtask

   // Sender goes quiet until every owed vertex is back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin : main
      reset <= 1'b1;
      hold_req <= 1'b0;
      rsp_stall_pct <= 0;
      send_idle_pct = 0;
      req_ch.valid <= 1'b0;
      req_ch.command <= OP_LOAD;
      req_ch.elem_index <= '0;
      req_ch.elem_value <= '0;
      req_ch.vec_x <= '0;
      req_ch.vec_y <= '0;
      req_ch.vec_z <= '0;
      req_ch.vec_w <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // cleared matrix gives zero even for extreme vectors
      transform(32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF, 32'sh0000_0001);
      // identity
      for (int i = 0; i < DIM; i++) load_elem(i*DIM + i, 32'sh0001_0000);
      transform(32'sh0001_0000, 32'sh0002_0000, 32'shFFFC_8000, 32'sh8000_0000);
      // row 0 at max: positive clip
      for (int i = 0; i < DIM; i++) load_elem(i, 32'sh7FFF_FFFF);
      transform(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      // row 1 at min: largest sum magnitude, then negative clip
      for (int i = 0; i < DIM; i++) load_elem(DIM + i, 32'sh8000_0000);
      transform(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      transform(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      // tiny negative product truncates to -1; row 2 lands exactly on max
      load_elem(3*DIM, 32'sh0000_0001);
      transform(32'shFFFF_FFFF, 32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000);
      drain();

      // random phases with different idling on each side
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_idle_pct = 61; rsp_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct <= 61; end
            default: begin send_idle_pct = 22; rsp_stall_pct <= 22; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long receiver hold-off while items keep coming
            if (ph == 0 && n == 40) hold_req <= 1'b1;
            send_random_item();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/vt4_pkg.sv
rtl/vt4_if.sv
rtl/vt4_front.sv
rtl/vt4_back.sv
rtl/vertex_transform_4x4_top.sv
rtl/vt4_checker.sv
dv/tb_top.sv
